### rtl/assert_macros.svh
// Assertion macros used by the checker module of the character buffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define CBID_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CBID_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/cbid_pkg.sv
// Types and constants shared by the character buffer modules.
package cbid_pkg;

	localparam int CAPACITY_DEF = 256;
	localparam int CHAR_W = 8;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SHIFT,
		S_PUT,
		S_DONE
	} state_t;

	// Finished result handed from the sequencer to the output register.
	typedef struct packed {
		logic              valid;
		status_t           status;
		logic [CHAR_W-1:0] char_out;
	} res_t;

endpackage

### rtl/cbid_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module cbid_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/cbid_ctrl.sv
// Command sequencer: decodes a beat, keeps the fill count and streams shifts through the RAM.
module cbid_ctrl import cbid_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int AW = $clog2(CAPACITY),
	localparam int LW = $clog2(CAPACITY + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [1:0]        command,
	input  logic [LW-1:0]     position,
	input  logic [CHAR_W-1:0] char_in,
	input  logic              res_take,
	output res_t              res,
	output logic [LW-1:0]     res_length,
	output logic              ram_we,
	output logic [AW-1:0]     ram_waddr,
	output logic [CHAR_W-1:0] ram_wdata,
	output logic              ram_re,
	output logic [AW-1:0]     ram_raddr,
	input  logic [CHAR_W-1:0] ram_rdata
);

	state_t            state_q, state_d;
	logic [LW-1:0]     fill_q;
	logic [LW-1:0]     left_q;
	logic [AW-1:0]     raddr_q;
	logic              ins_q;
	logic [AW-1:0]     pos_q;
	logic [CHAR_W-1:0] char_q;
	status_t           status_q;
	logic [CHAR_W-1:0] rd_char_q;
	logic              v_s1;
	logic [AW-1:0]     waddr_s1;

	logic              accept;
	logic              issue;
	status_t           dec_status;
	state_t            dec_next;
	logic [LW-1:0]     dec_fill;
	logic [LW-1:0]     dec_left;
	logic [AW-1:0]     dec_addr;

	assign accept = req_valid && (state_q == S_IDLE);
	assign issue  = (state_q == S_SHIFT) && (left_q != '0);

	// Decode of the incoming beat against the current fill count.
	always_comb begin
		dec_status = ST_OK;
		dec_next   = S_DONE;
		dec_fill   = fill_q;
		dec_left   = '0;
		dec_addr   = '0;
		case (cmd_t'(command))
			CMD_INSERT: begin
				if (fill_q == LW'(CAPACITY)) begin
					dec_status = ST_FULL;
				end else if (position > fill_q) begin
					dec_status = ST_RANGE;
				end else begin
					dec_fill = fill_q + LW'(1);
					dec_left = fill_q - position;
					dec_addr = AW'(fill_q - LW'(1));
					dec_next = S_SHIFT;
				end
			end
			CMD_REMOVE: begin
				if (position >= fill_q) begin
					dec_status = ST_RANGE;
				end else begin
					dec_fill = fill_q - LW'(1);
					dec_left = fill_q - position - LW'(1);
					dec_addr = AW'(position + LW'(1));
					dec_next = S_SHIFT;
				end
			end
			CMD_READ: begin
				if (position >= fill_q) begin
					dec_status = ST_RANGE;
				end else begin
					dec_next = S_READ;
				end
			end
			default: begin
				dec_status = ST_RANGE;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = dec_next;
				end
			end
			S_READ: begin
				state_d = S_DONE;
			end
			S_SHIFT: begin
				// The last shifted byte is written in this cycle, the cycle after its read.
				if (left_q == '0) begin
					state_d = ins_q ? S_PUT : S_DONE;
				end
			end
			S_PUT: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall    = (state_q != S_IDLE);
		res.valid    = (state_q == S_DONE);
		res.status   = status_q;
		res.char_out = rd_char_q;
		res_length   = fill_q;
		ram_re       = issue || accept;
		ram_raddr    = (state_q == S_IDLE) ? AW'(position) : raddr_q;
		ram_we       = v_s1 || (state_q == S_PUT);
		ram_waddr    = v_s1 ? waddr_s1 : pos_q;
		ram_wdata    = v_s1 ? ram_rdata : char_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			left_q  <= '0;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			if (accept) begin
				fill_q <= dec_fill;
				left_q <= dec_left;
			end else if (issue) begin
				left_q <= left_q - LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ins_q     <= (cmd_t'(command) == CMD_INSERT);
			pos_q     <= AW'(position);
			char_q    <= char_in;
			raddr_q   <= dec_addr;
			status_q  <= dec_status;
			rd_char_q <= '0;
		end
		if (issue) begin
			raddr_q  <= ins_q ? raddr_q - AW'(1) : raddr_q + AW'(1);
			waddr_s1 <= ins_q ? raddr_q + AW'(1) : raddr_q - AW'(1);
		end
		if (state_q == S_READ) begin
			rd_char_q <= ram_rdata;
		end
	end

endmodule

### rtl/char_buffer_insert_delete.sv
// Character buffer with insert, remove and read at an index (top level).
//
// The buffer holds up to CAPACITY bytes in one RAM plus a fill count. Every request beat gives
// exactly one response beat with the length after the command and a status. Commands are
// taken one at a time: a read passes through S_READ, an insert through S_SHIFT and S_PUT and
// a remove through S_SHIFT before S_DONE, while a rejected command goes straight to S_DONE.
// An insert at position p shifts length - p bytes and a remove at p shifts length - p - 1,
// where length is the count before the command. The shift loop moves one byte per cycle
// through the single read port and single write port of the RAM. A finished response sits in
// an output register, so a new request is taken while the previous response waits.
module char_buffer_insert_delete import cbid_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int AW = $clog2(CAPACITY),
	localparam int LW = $clog2(CAPACITY + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [1:0]        command,
	input  logic [LW-1:0]     position,
	input  logic [CHAR_W-1:0] char_in,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [CHAR_W-1:0] char_out,
	output logic [LW-1:0]     length,
	output logic [1:0]        status
);

	res_t              res;
	logic [LW-1:0]     res_length;
	logic              res_take;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CHAR_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [CHAR_W-1:0] ram_rdata;
	logic              rsp_valid_q;
	logic [CHAR_W-1:0] char_out_q;
	logic [LW-1:0]     length_q;
	status_t           status_q;

	cbid_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.command   (command),
		.position  (position),
		.char_in   (char_in),
		.res_take  (res_take),
		.res       (res),
		.res_length(res_length),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	cbid_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// The output register can take a new result when it is empty or its beat leaves now.
	assign res_take = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res.valid) begin
			char_out_q <= res.char_out;
			length_q   <= res_length;
			status_q   <= res.status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign char_out  = char_out_q;
	assign length    = length_q;
	assign status    = status_q;

endmodule

### rtl/cbid_checker.sv
// Port-level checker for the character buffer and its bind to the top level.
`include "assert_macros.svh"

module cbid_checker import cbid_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int LW = $clog2(CAPACITY + 1)
) (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input logic [CHAR_W-1:0] char_out,
	input logic [LW-1:0]     length,
	input logic [1:0]        status
);

	`CBID_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(length) && $stable(status) && $stable(char_out), "stalled response beat changed")
	`CBID_ASSERT(a_len_cap, rsp_valid |-> length <= LW'(CAPACITY), "length exceeds capacity")
	`CBID_ASSERT(a_full_len, rsp_valid && (status == ST_FULL) |-> length == LW'(CAPACITY), "full status with room left")
	`CBID_ASSERT(a_char_zero, rsp_valid && (status != ST_OK) |-> char_out == '0, "byte returned on a failed command")
	`CBID_ASSERT(a_busy, req_valid && !req_stall |=> req_stall, "request taken while a command is in progress")

endmodule

bind char_buffer_insert_delete cbid_checker #(.CAPACITY(CAPACITY)) u_checker (.*);
